// ===== rtl/imuc_pkg.sv =====
// ----------------------------------------------------------------------------
// imuc_pkg: shared types and constants of the IMU error compensator
// Register map codes, sensor kind codes and the load enables that the top
// level hands to each axis lane.
// ----------------------------------------------------------------------------
package imuc_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MIS_A = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MIS_B = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_MIS_A  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_MIS_B  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 4'd7;

	localparam logic KIND_ACCEL = 1'b0;
	localparam logic KIND_GYRO  = 1'b1;

	// Load enables of the pipeline stages that live inside each lane.
	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
	} lane_en_t;

endpackage

// ===== rtl/imuc_lane.sv =====
// ----------------------------------------------------------------------------
// imuc_lane: one axis of the compensation datapath
// Two misalignment products, the rounded row sum, the scale product, then
// rounding and saturation of the axis result.
// ----------------------------------------------------------------------------
module imuc_lane #(
	parameter int MEAS_WIDTH = 20,
	parameter int COEF_WIDTH = 16
) (
	input  logic                         clk,
	input  imuc_pkg::lane_en_t           en,
	input  logic signed [MEAS_WIDTH:0]   d_self,
	input  logic signed [MEAS_WIDTH:0]   d_a,
	input  logic signed [MEAS_WIDTH:0]   d_b,
	input  logic signed [COEF_WIDTH-1:0] m_a,
	input  logic signed [COEF_WIDTH-1:0] m_b,
	input  logic signed [COEF_WIDTH-1:0] scale,
	output logic signed [MEAS_WIDTH-1:0] res,
	output logic                         clip
);

	localparam int DW = MEAS_WIDTH + 1;
	localparam int PW = MEAS_WIDTH + COEF_WIDTH + 1;
	localparam int QW = MEAS_WIDTH + 2;
	localparam int VW = MEAS_WIDTH + 3;
	localparam int MW = COEF_WIDTH + VW;
	localparam int SW = MW + 1;

	localparam logic signed [PW:0]   RND_M = (PW+1)'(1) << (COEF_WIDTH - 2);
	localparam logic signed [SW-1:0] RND_S = SW'(1) << (COEF_WIDTH - 3);
	localparam logic signed [SW-1:0] MAXV  = SW'((1 << (MEAS_WIDTH - 1)) - 1);
	localparam logic signed [SW-1:0] MINV  = SW'(-(1 << (MEAS_WIDTH - 1)));

	logic signed [PW-1:0]         pa_s2, pb_s2;
	logic signed [DW-1:0]         d_s2;
	logic signed [COEF_WIDTH-1:0] sc_s2, sc_s3;
	logic signed [VW-1:0]         v_s3;
	logic signed [MW-1:0]         sv_s4;

	logic signed [PW:0]   pa_rnd, pb_rnd;
	logic signed [QW-1:0] qa, qb;
	logic signed [VW-1:0] v_sum;
	logic signed [SW-1:0] r_full;

	always_ff @(posedge clk) begin
		if (en.ld2) begin
			pa_s2 <= m_a * d_a;
			pb_s2 <= m_b * d_b;
			d_s2  <= d_self;
			sc_s2 <= scale;
		end
		if (en.ld3) begin
			v_s3  <= v_sum;
			sc_s3 <= sc_s2;
		end
		if (en.ld4) begin
			sv_s4 <= sc_s3 * v_s3;
		end
	end

	// Arithmetic right shift of a signed value is a floor, so adding half
	// first gives round half up.
	always_comb begin
		pa_rnd = (PW+1)'(pa_s2) + RND_M;
		pb_rnd = (PW+1)'(pb_s2) + RND_M;
		qa     = QW'(pa_rnd >>> (COEF_WIDTH - 1));
		qb     = QW'(pb_rnd >>> (COEF_WIDTH - 1));
		v_sum  = VW'(d_s2) + VW'(qa) + VW'(qb);
	end

	always_comb begin
		r_full = (SW'(sv_s4) + RND_S) >>> (COEF_WIDTH - 2);
		clip   = 1'b0;
		res    = r_full[MEAS_WIDTH-1:0];
		if (r_full > MAXV) begin
			res  = MAXV[MEAS_WIDTH-1:0];
			clip = 1'b1;
		end else if (r_full < MINV) begin
			res  = MINV[MEAS_WIDTH-1:0];
			clip = 1'b1;
		end
	end

endmodule

// ===== rtl/imuc_merge.sv =====
// ----------------------------------------------------------------------------
// imuc_merge: output stage
// Gathers the three lane results into one result transaction and combines
// the per-axis saturation flags.
// ----------------------------------------------------------------------------
module imuc_merge #(
	parameter int MEAS_WIDTH = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         lane_valid,
	input  logic                         lane_kind,
	input  logic signed [MEAS_WIDTH-1:0] res_x,
	input  logic signed [MEAS_WIDTH-1:0] res_y,
	input  logic signed [MEAS_WIDTH-1:0] res_z,
	input  logic                         clip_x,
	input  logic                         clip_y,
	input  logic                         clip_z,
	output logic                         room,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         kind,
	output logic signed [MEAS_WIDTH-1:0] out_x,
	output logic signed [MEAS_WIDTH-1:0] out_y,
	output logic signed [MEAS_WIDTH-1:0] out_z,
	output logic                         clipped
);

	logic valid_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (room && lane_valid) begin
			kind    <= lane_kind;
			out_x   <= res_x;
			out_y   <= res_y;
			out_z   <= res_z;
			clipped <= clip_x | clip_y | clip_z;
		end
	end

endmodule

// ===== rtl/imu_error_compensator.sv =====
// ----------------------------------------------------------------------------
// imu_error_compensator: bias, misalignment and scale correction of IMU data
// Applies out = diag(scale) * M * (meas - bias) with the stored model of the
// accelerometer or the gyroscope, in three axis lanes side by side.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one three-axis sample and the
// sensor kind in command. Each transaction yields exactly one result on the
// output channel (out_valid/out_ready): the echoed kind, three saturated axis
// values and the clipped flag, in input order.
// The datapath is five stages deep: bias subtraction and model selection,
// misalignment products, row sum, scale product, then rounding, saturation and
// the output register. One sample is accepted every cycle while in_ready is
// high; the two 21 x 16 multipliers per lane and the scale multiplier per lane
// each have a stage of their own, so they do not hold back that rate.
// When the receiver stalls, each stage holds only while the one after it is
// full, so empty stages keep filling and in_ready falls only once all five
// stages hold results.
// The configuration channel (cfg_valid/cfg_ready) is always ready; writes to
// an index beyond the register map are ignored and are meant to happen only
// while no sample is in flight. Reset empties the pipeline, clears biases and
// misalignment and sets every scale factor to one.
// ----------------------------------------------------------------------------
module imu_error_compensator #(
	parameter int MEAS_WIDTH = 20,
	parameter int COEF_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [imuc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [3*((MEAS_WIDTH > COEF_WIDTH) ? MEAS_WIDTH : COEF_WIDTH)-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic signed [MEAS_WIDTH-1:0]        meas_x,
	input  logic signed [MEAS_WIDTH-1:0]        meas_y,
	input  logic signed [MEAS_WIDTH-1:0]        meas_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                kind,
	output logic signed [MEAS_WIDTH-1:0]        out_x,
	output logic signed [MEAS_WIDTH-1:0]        out_y,
	output logic signed [MEAS_WIDTH-1:0]        out_z,
	output logic                                clipped
);

	localparam int BW    = 3 * MEAS_WIDTH;
	localparam int CWR   = 3 * COEF_WIDTH;
	localparam int DW    = MEAS_WIDTH + 1;

	localparam logic [COEF_WIDTH-1:0] SCALE_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 2);
	localparam logic [CWR-1:0]        SCALE_RST = {3{SCALE_ONE}};

	// Configuration registers.
	logic [BW-1:0]  acc_bias_q, gyr_bias_q;
	logic [CWR-1:0] acc_mis_a_q, acc_mis_b_q, acc_scale_q;
	logic [CWR-1:0] gyr_mis_a_q, gyr_mis_b_q, gyr_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_bias_q  <= '0;
			acc_mis_a_q <= '0;
			acc_mis_b_q <= '0;
			acc_scale_q <= SCALE_RST;
			gyr_bias_q  <= '0;
			gyr_mis_a_q <= '0;
			gyr_mis_b_q <= '0;
			gyr_scale_q <= SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				imuc_pkg::REG_ACCEL_BIAS:  acc_bias_q  <= cfg_data[BW-1:0];
				imuc_pkg::REG_ACCEL_MIS_A: acc_mis_a_q <= cfg_data[CWR-1:0];
				imuc_pkg::REG_ACCEL_MIS_B: acc_mis_b_q <= cfg_data[CWR-1:0];
				imuc_pkg::REG_ACCEL_SCALE: acc_scale_q <= cfg_data[CWR-1:0];
				imuc_pkg::REG_GYRO_BIAS:   gyr_bias_q  <= cfg_data[BW-1:0];
				imuc_pkg::REG_GYRO_MIS_A:  gyr_mis_a_q <= cfg_data[CWR-1:0];
				imuc_pkg::REG_GYRO_MIS_B:  gyr_mis_b_q <= cfg_data[CWR-1:0];
				imuc_pkg::REG_GYRO_SCALE:  gyr_scale_q <= cfg_data[CWR-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline occupancy. A stage may load when it is empty or when the
	// stage after it can load as well.
	logic v_s1, v_s2, v_s3, v_s4;
	logic free1, free2, free3, free4, free5;
	logic kind_s1, kind_s2, kind_s3, kind_s4;
	imuc_pkg::lane_en_t lane_en;

	assign free4    = !v_s4 || free5;
	assign free3    = !v_s3 || free4;
	assign free2    = !v_s2 || free3;
	assign free1    = !v_s1 || free2;
	assign in_ready = free1;

	assign lane_en.ld2 = free2 && v_s1;
	assign lane_en.ld3 = free3 && v_s2;
	assign lane_en.ld4 = free4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free1) v_s1 <= in_valid;
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
			if (free4) v_s4 <= v_s3;
		end
	end

	// Stage 1: select the sensor's model and subtract the bias.
	logic [BW-1:0]  bias_sel;
	logic [CWR-1:0] mis_a_sel, mis_b_sel, scale_sel;

	logic signed [DW-1:0]         d_s1 [3];
	logic signed [COEF_WIDTH-1:0] m_s1 [6];
	logic signed [COEF_WIDTH-1:0] sc_s1 [3];

	always_comb begin
		if (command == imuc_pkg::KIND_GYRO) begin
			bias_sel  = gyr_bias_q;
			mis_a_sel = gyr_mis_a_q;
			mis_b_sel = gyr_mis_b_q;
			scale_sel = gyr_scale_q;
		end else begin
			bias_sel  = acc_bias_q;
			mis_a_sel = acc_mis_a_q;
			mis_b_sel = acc_mis_b_q;
			scale_sel = acc_scale_q;
		end
	end

	always_ff @(posedge clk) begin
		if (free1 && in_valid) begin
			kind_s1 <= command;
			d_s1[0] <= DW'(meas_x) - DW'($signed(bias_sel[MEAS_WIDTH-1:0]));
			d_s1[1] <= DW'(meas_y) - DW'($signed(bias_sel[2*MEAS_WIDTH-1:MEAS_WIDTH]));
			d_s1[2] <= DW'(meas_z) - DW'($signed(bias_sel[3*MEAS_WIDTH-1:2*MEAS_WIDTH]));
			for (int i = 0; i < 3; i++) begin
				m_s1[i]   <= mis_a_sel[i*COEF_WIDTH +: COEF_WIDTH];
				m_s1[3+i] <= mis_b_sel[i*COEF_WIDTH +: COEF_WIDTH];
				sc_s1[i]  <= scale_sel[i*COEF_WIDTH +: COEF_WIDTH];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lane_en.ld2) kind_s2 <= kind_s1;
		if (lane_en.ld3) kind_s3 <= kind_s2;
		if (lane_en.ld4) kind_s4 <= kind_s3;
	end

	// Axis lanes: row x uses m0,m1; row y uses m2,m3; row z uses m4,m5.
	logic signed [MEAS_WIDTH-1:0] res_x, res_y, res_z;
	logic                         clip_x, clip_y, clip_z;

	imuc_lane #(.MEAS_WIDTH(MEAS_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane_x (
		.clk(clk), .en(lane_en),
		.d_self(d_s1[0]), .d_a(d_s1[1]), .d_b(d_s1[2]),
		.m_a(m_s1[0]), .m_b(m_s1[1]), .scale(sc_s1[0]),
		.res(res_x), .clip(clip_x)
	);

	imuc_lane #(.MEAS_WIDTH(MEAS_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane_y (
		.clk(clk), .en(lane_en),
		.d_self(d_s1[1]), .d_a(d_s1[0]), .d_b(d_s1[2]),
		.m_a(m_s1[2]), .m_b(m_s1[3]), .scale(sc_s1[1]),
		.res(res_y), .clip(clip_y)
	);

	imuc_lane #(.MEAS_WIDTH(MEAS_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane_z (
		.clk(clk), .en(lane_en),
		.d_self(d_s1[2]), .d_a(d_s1[0]), .d_b(d_s1[1]),
		.m_a(m_s1[4]), .m_b(m_s1[5]), .scale(sc_s1[2]),
		.res(res_z), .clip(clip_z)
	);

	imuc_merge #(.MEAS_WIDTH(MEAS_WIDTH)) u_merge (
		.clk(clk), .arst_n(arst_n),
		.lane_valid(v_s4), .lane_kind(kind_s4),
		.res_x(res_x), .res_y(res_y), .res_z(res_z),
		.clip_x(clip_x), .clip_y(clip_y), .clip_z(clip_z),
		.room(free5),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.clipped(clipped)
	);

	// An accepted transaction always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted sample did not enter stage 1");

	// A stalled last stage keeps its item and its kind.
	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !free5 |=> v_s4 && $stable(kind_s4))
		else $error("stage 4 item lost during stall");

	// An empty first stage never blocks the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input blocked with stage 1 empty");

	// The input is only held back when every stage is full.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && out_valid && !out_ready)
		else $error("input stalled with a free stage");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the IMU error compensator
// Drives sensor samples and register writes through their handshakes, keeps
// its own fixed-point model of the bias, misalignment and scale correction,
// and checks every result against it in order. Traffic runs from the default
// model through directed extremes to random models, with random gaps on both
// sides and one long output stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MW = 20;
	localparam int CW = 16;
	localparam int NUM_REGS = 8;
	localparam longint MAX_OUT = (longint'(1) << (MW - 1)) - 1;
	localparam longint MIN_OUT = -(longint'(1) << (MW - 1));
	localparam logic [MW-1:0] MEAS_MAX = 20'h7FFFF;
	localparam logic [MW-1:0] MEAS_MIN = 20'h80000;
	localparam logic [CW-1:0] UNITY = 16'h4000;

	typedef struct {
		logic          kind;
		logic [MW-1:0] axis[3];
		logic          clipped;
	} comp_result_t;

	// Model of the compensator: register copy, expected results, mismatch count.
	class comp_scoreboard;
		logic [59:0]  regs[NUM_REGS];
		comp_result_t pending_corrections[$];
		int unsigned  mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			regs[imuc_pkg::REG_ACCEL_SCALE] = {12'd0, UNITY, UNITY, UNITY};
			regs[imuc_pkg::REG_GYRO_SCALE]  = {12'd0, UNITY, UNITY, UNITY};
			mismatches = 0;
		endfunction

		function void write_reg(logic [imuc_pkg::CFG_IDX_W-1:0] idx, logic [59:0] data);
			if (idx < NUM_REGS) begin
				if (idx == imuc_pkg::REG_ACCEL_BIAS || idx == imuc_pkg::REG_GYRO_BIAS)
					regs[idx] = data;
				else
					regs[idx] = {12'd0, data[47:0]};
			end
		endfunction

		function longint sfield(logic [59:0] r, int i, int w);
			longint v;
			v = longint'((r >> (i * w)) & ((60'd1 << w) - 60'd1));
			if (v[w-1])
				v = v - (longint'(1) << w);
			return v;
		endfunction

		// Misalignment product, rounded half up.
		function longint mis_term(longint m, longint d);
			return (m * d + (longint'(1) << (CW - 2))) >>> (CW - 1);
		endfunction

		function void note_sample(logic cmd, logic signed [MW-1:0] mx,
				logic signed [MW-1:0] my, logic signed [MW-1:0] mz);
			logic [59:0]  bias, mis_a, mis_b, scale;
			longint       meas[3], d[3], m[6], v[3];
			longint       s, r;
			comp_result_t e;
			meas[0] = longint'(mx);
			meas[1] = longint'(my);
			meas[2] = longint'(mz);
			if (cmd == imuc_pkg::KIND_GYRO) begin
				bias  = regs[imuc_pkg::REG_GYRO_BIAS];
				mis_a = regs[imuc_pkg::REG_GYRO_MIS_A];
				mis_b = regs[imuc_pkg::REG_GYRO_MIS_B];
				scale = regs[imuc_pkg::REG_GYRO_SCALE];
			end else begin
				bias  = regs[imuc_pkg::REG_ACCEL_BIAS];
				mis_a = regs[imuc_pkg::REG_ACCEL_MIS_A];
				mis_b = regs[imuc_pkg::REG_ACCEL_MIS_B];
				scale = regs[imuc_pkg::REG_ACCEL_SCALE];
			end
			for (int i = 0; i < 3; i++) begin
				d[i] = meas[i] - sfield(bias, i, MW);
				m[i] = sfield(mis_a, i, CW);
				m[3+i] = sfield(mis_b, i, CW);
			end
			v[0] = d[0] + mis_term(m[0], d[1]) + mis_term(m[1], d[2]);
			v[1] = mis_term(m[2], d[0]) + d[1] + mis_term(m[3], d[2]);
			v[2] = mis_term(m[4], d[0]) + mis_term(m[5], d[1]) + d[2];
			e.kind = cmd;
			e.clipped = 1'b0;
			for (int i = 0; i < 3; i++) begin
				s = sfield(scale, i, CW);
				r = (s * v[i] + (longint'(1) << (CW - 3))) >>> (CW - 2);
				if (r > MAX_OUT) begin
					r = MAX_OUT;
					e.clipped = 1'b1;
				end
				if (r < MIN_OUT) begin
					r = MIN_OUT;
					e.clipped = 1'b1;
				end
				e.axis[i] = r[MW-1:0];
			end
			pending_corrections.push_back(e);
		endfunction

		function void check_correction(comp_result_t got);
			comp_result_t e;
			if (pending_corrections.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no sample outstanding: kind=%0d x=%0d",
						$time, got.kind, $signed(got.axis[0]));
				return;
			end
			e = pending_corrections.pop_front();
			if (got.kind !== e.kind || got.clipped !== e.clipped ||
					got.axis[0] !== e.axis[0] || got.axis[1] !== e.axis[1] ||
					got.axis[2] !== e.axis[2]) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch, expected kind=%0d x=%0d y=%0d z=%0d clipped=%0d",
						$time, e.kind, $signed(e.axis[0]), $signed(e.axis[1]),
						$signed(e.axis[2]), e.clipped);
					$display("%0t:           actual kind=%0d x=%0d y=%0d z=%0d clipped=%0d",
						$time, got.kind, $signed(got.axis[0]), $signed(got.axis[1]),
						$signed(got.axis[2]), got.clipped);
				end
			end
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [imuc_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [59:0]                          cfg_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic                                 command;
	logic signed [MW-1:0]                 meas_x, meas_y, meas_z;
	logic                                 out_valid;
	logic                                 out_ready;
	logic                                 kind;
	logic signed [MW-1:0]                 out_x, out_y, out_z;
	logic                                 clipped;

	comp_scoreboard sb;
	bit             no_idle;
	bit             hold_req;

	imu_error_compensator #(
		.MEAS_WIDTH(MW),
		.COEF_WIDTH(CW)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.meas_x   (meas_x),
		.meas_y   (meas_y),
		.meas_z   (meas_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z),
		.clipped  (clipped)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [MW-1:0] rand_meas();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: return MEAS_MAX;
				1: return MEAS_MIN;
				2: return '0;
				3: return '1;
				default: return 20'd1;
			endcase
		end
		if (r < 5)
			return MW'($urandom_range(0, 4000) - 2000);
		return MW'($urandom);
	endfunction

	function automatic logic [59:0] rand_bias3();
		logic [MW-1:0] f[3];
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 9))
				0: f[i] = ($urandom_range(0, 1) != 0) ? MEAS_MAX : MEAS_MIN;
				1, 2, 3: f[i] = MW'($urandom);
				default: f[i] = MW'($urandom_range(0, 10000) - 5000);
			endcase
		end
		return {f[2], f[1], f[0]};
	endfunction

	// Upper bits beyond the 48-bit register are filled with noise on purpose.
	function automatic logic [59:0] rand_coef3(bit is_scale);
		logic [CW-1:0] f[3];
		int r;
		for (int i = 0; i < 3; i++) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				f[i] = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
			else if (r < 3)
				f[i] = is_scale ? UNITY : 16'h0000;
			else if (r < 7)
				f[i] = CW'($urandom);
			else if (is_scale)
				f[i] = CW'(16384 + $urandom_range(0, 4000) - 2000);
			else
				f[i] = CW'($urandom_range(0, 8191) - 4096);
		end
		return {12'($urandom), f[2], f[1], f[0]};
	endfunction

	task automatic cfg_write(input logic [imuc_pkg::CFG_IDX_W-1:0] idx,
			input logic [59:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic program_model(input logic [59:0] vals[NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++)
			cfg_write(imuc_pkg::CFG_IDX_W'(i), vals[i]);
		// Writes past the register map must leave the model untouched.
		if ($urandom_range(0, 1) != 0)
			cfg_write(imuc_pkg::CFG_IDX_W'($urandom_range(NUM_REGS, 15)),
				60'({$urandom, $urandom}));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_model();
		logic [59:0] vals[NUM_REGS];
		vals[imuc_pkg::REG_ACCEL_BIAS]  = rand_bias3();
		vals[imuc_pkg::REG_ACCEL_MIS_A] = rand_coef3(1'b0);
		vals[imuc_pkg::REG_ACCEL_MIS_B] = rand_coef3(1'b0);
		vals[imuc_pkg::REG_ACCEL_SCALE] = rand_coef3(1'b1);
		vals[imuc_pkg::REG_GYRO_BIAS]   = rand_bias3();
		vals[imuc_pkg::REG_GYRO_MIS_A]  = rand_coef3(1'b0);
		vals[imuc_pkg::REG_GYRO_MIS_B]  = rand_coef3(1'b0);
		vals[imuc_pkg::REG_GYRO_SCALE]  = rand_coef3(1'b1);
		program_model(vals);
	endtask

	task automatic send_sample(input logic cmd, input logic [MW-1:0] x,
			input logic [MW-1:0] y, input logic [MW-1:0] z);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command  <= cmd;
		meas_x   <= x;
		meas_y   <= y;
		meas_z   <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_sample(cmd, x, y, z);
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_sample(($urandom_range(0, 1) != 0) ? imuc_pkg::KIND_GYRO
				: imuc_pkg::KIND_ACCEL, rand_meas(), rand_meas(), rand_meas());
	endtask

	// Stop offering samples and let the pipeline run dry before the next phase.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_corrections.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
	endtask

	// Output side: random ready bursts and stalls, plus one long hold-off on request.
	initial begin
		int n;
		bit held;
		out_ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (59)
					@(negedge clk);
				held = 1'b1;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					@(negedge clk);
					out_ready <= 1'b0;
					repeat (n - 1)
						@(negedge clk);
				end
				n = $urandom_range(1, 16);
				@(negedge clk);
				out_ready <= 1'b1;
				repeat (n - 1)
					@(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		comp_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind    = kind;
			got.axis[0] = out_x;
			got.axis[1] = out_y;
			got.axis[2] = out_z;
			got.clipped = clipped;
			sb.check_correction(got);
		end
	end

	initial begin
		#10_000_000;
		$display("** imu_error_compensator: FAILED **");
		$finish;
	end

	initial begin
		logic [59:0] vals[NUM_REGS];
		sb        = new();
		no_idle   = 1'b0;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		command   = imuc_pkg::KIND_ACCEL;
		meas_x    = '0;
		meas_y    = '0;
		meas_z    = '0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default model: unit scale, no bias, no misalignment.
		send_sample(imuc_pkg::KIND_ACCEL, '0, '0, '0);
		send_sample(imuc_pkg::KIND_GYRO, MEAS_MAX, MEAS_MAX, MEAS_MAX);
		send_sample(imuc_pkg::KIND_ACCEL, MEAS_MIN, MEAS_MIN, MEAS_MIN);
		send_sample(imuc_pkg::KIND_GYRO, MEAS_MAX, MEAS_MIN, 20'd1);
		send_sample(imuc_pkg::KIND_ACCEL, '1, 20'd1, 20'h80001);
		drain();

		// Half-valued misalignment and 1.5 scale hit the rounding ties on both
		// signs; the gyroscope model gets extreme biases and -1 misalignment.
		vals[imuc_pkg::REG_ACCEL_BIAS]  = '0;
		vals[imuc_pkg::REG_ACCEL_MIS_A] = {12'hFFF, {3{16'h4000}}};
		vals[imuc_pkg::REG_ACCEL_MIS_B] = {12'hA5A, {3{16'h4000}}};
		vals[imuc_pkg::REG_ACCEL_SCALE] = {12'h000, {3{16'h6000}}};
		vals[imuc_pkg::REG_GYRO_BIAS]   = {20'd1, MEAS_MIN, MEAS_MAX};
		vals[imuc_pkg::REG_GYRO_MIS_A]  = {12'h5A5, {3{16'h8000}}};
		vals[imuc_pkg::REG_GYRO_MIS_B]  = {12'hFFF, {3{16'h8000}}};
		vals[imuc_pkg::REG_GYRO_SCALE]  = {12'h800, {3{16'h7FFF}}};
		program_model(vals);
		send_sample(imuc_pkg::KIND_ACCEL, 20'd1, 20'd1, 20'd1);
		send_sample(imuc_pkg::KIND_ACCEL, '1, '1, '1);
		send_sample(imuc_pkg::KIND_ACCEL, 20'd3, -20'sd3, 20'd1);
		send_sample(imuc_pkg::KIND_ACCEL, -20'sd3, 20'd3, '1);
		send_sample(imuc_pkg::KIND_ACCEL, MEAS_MAX, MEAS_MAX, MEAS_MAX);
		send_sample(imuc_pkg::KIND_ACCEL, MEAS_MIN, MEAS_MIN, MEAS_MIN);
		send_sample(imuc_pkg::KIND_GYRO, MEAS_MIN, MEAS_MAX, '0);
		send_sample(imuc_pkg::KIND_GYRO, MEAS_MAX, MEAS_MIN, MEAS_MIN);
		send_sample(imuc_pkg::KIND_GYRO, '0, '0, 20'd1);
		send_sample(imuc_pkg::KIND_GYRO, MEAS_MAX, MEAS_MIN, 20'd1);
		drain();

		// Coefficient extremes, including zero scale.
		vals[imuc_pkg::REG_ACCEL_BIAS]  = {3{MEAS_MIN}};
		vals[imuc_pkg::REG_ACCEL_MIS_A] = {12'h000, {3{16'h7FFF}}};
		vals[imuc_pkg::REG_ACCEL_MIS_B] = {12'hFFF, {3{16'h7FFF}}};
		vals[imuc_pkg::REG_ACCEL_SCALE] = {12'h123, {3{16'h8000}}};
		vals[imuc_pkg::REG_GYRO_BIAS]   = {3{MEAS_MAX}};
		vals[imuc_pkg::REG_GYRO_MIS_A]  = {12'h000, 16'h7FFF, 16'h8000, 16'h7FFF};
		vals[imuc_pkg::REG_GYRO_MIS_B]  = {12'hFFF, 16'h7FFF, 16'h0000, 16'h8000};
		vals[imuc_pkg::REG_GYRO_SCALE]  = {12'hFFF, {3{16'h0000}}};
		program_model(vals);
		send_random(80);
		drain();

		for (int p = 0; p < 8; p++) begin
			random_model();
			no_idle = ($urandom_range(0, 3) == 0);
			send_random(125);
			drain();
		end

		// Long output stall with the input kept busy, so the pipeline fills up.
		random_model();
		no_idle = 1'b1;
		hold_req = 1'b1;
		send_random(60);
		no_idle = 1'b0;
		drain();

		if (sb.mismatches == 0 && sb.pending_corrections.size() == 0)
			$display("** imu_error_compensator: PASSED **");
		else
			$display("** imu_error_compensator: FAILED **");
		$finish;
	end

endmodule
